// ===== hdl/dfir_pkg.sv =====
// ----------------------------------------------------------------------------
// dfir_pkg
// Shared constants, register indexes and controller/datapath link types for
// the decimating FIR filter.
// ----------------------------------------------------------------------------
package dfir_pkg;

    // Fixed field widths
    localparam int COEF_BITS     = 18;
    localparam int COEF_IDX_BITS = 8;
    localparam int DECIM_BITS    = 11;
    localparam int TAPS_BITS     = 9;
    localparam int PHASE_BITS    = 10;
    localparam int DECIM_MAX     = 1024;
    localparam int FRAC_SHIFT    = 17;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_IDX_BITS-1:0] REG_DECIM_FACTOR = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_IN_USE  = 1'b1;

    localparam logic [DECIM_BITS-1:0] DECIM_RESET = 11'd10;
    localparam logic [TAPS_BITS-1:0]  TAPS_RESET  = 9'd151;

    // Input operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic push;   // write sample into delay line, advance write pointer
        logic load;   // write coefficient store
        logic start;  // clear accumulator, point read pointer at newest sample
        logic issue;  // read one tap pair and send it down the MAC pipe
        logic round;  // round and shift the accumulator
        logic emit;   // saturate into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic pipe_busy; // MAC pipe still holds a tap
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

// ===== hdl/dfir_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfir_ctrl
// Sequencer for the decimating FIR filter: decodes input beats, keeps the
// decimation phase and configuration, and steps the shared MAC over taps.
// ----------------------------------------------------------------------------
module dfir_ctrl #(
    parameter int MAX_TAPS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel control
    input  logic                                 i_in_valid,
    input  logic                                 i_opcode,
    output logic                                 o_in_stall,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dfir_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [dfir_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // datapath link
    input  dfir_pkg::t_dp_stat                   i_stat,
    output dfir_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(MAX_TAPS)-1:0]          o_tap
);
    import dfir_pkg::*;

    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = (CNT_W > TAPS_BITS) ? CNT_W : TAPS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND,
        S_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [PHASE_BITS-1:0]   r_phase, n_phase;
    logic [DECIM_BITS-1:0]   r_decim, n_decim;
    logic [TAPS_BITS-1:0]    r_taps,  n_taps;
    logic [TAP_W-1:0]        r_tap,   n_tap;

    logic                    accept;
    logic [DECIM_BITS-1:0]   factor_eff;
    logic [DECIM_BITS-1:0]   phase_inc;
    logic [CMP_W-1:0]        taps_raw;
    logic [CMP_W-1:0]        taps_eff;
    logic                    last_tap;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_tap       = r_tap;
    assign accept      = i_in_valid && (r_state == S_IDLE);

    // Clamp decimation factor into 1..1024
    always_comb begin
        if (r_decim == '0) begin
            factor_eff = DECIM_BITS'(1);
        end else if (r_decim > DECIM_BITS'(DECIM_MAX)) begin
            factor_eff = DECIM_BITS'(DECIM_MAX);
        end else begin
            factor_eff = r_decim;
        end
    end

    assign phase_inc = {1'b0, r_phase} + DECIM_BITS'(1);

    // Clamp tap count into 1..MAX_TAPS
    assign taps_raw = CMP_W'(r_taps);
    always_comb begin
        if (taps_raw == '0) begin
            taps_eff = CMP_W'(1);
        end else if (taps_raw > CMP_W'(MAX_TAPS)) begin
            taps_eff = CMP_W'(MAX_TAPS);
        end else begin
            taps_eff = taps_raw;
        end
    end

    assign last_tap = (CMP_W'(r_tap) == (taps_eff - CMP_W'(1)));

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_decim = r_decim;
        n_taps  = r_taps;
        n_tap   = r_tap;
        o_cmd   = '0;

        // take configuration writes
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DECIM_FACTOR: n_decim = i_cfg_data[DECIM_BITS-1:0];
                REG_TAPS_IN_USE:  n_taps  = i_cfg_data[TAPS_BITS-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                        if (phase_inc >= factor_eff) begin
                            n_phase = '0;
                        end else begin
                            n_phase = phase_inc[PHASE_BITS-1:0];
                        end
                        if (r_phase == '0) begin
                            o_cmd.start = 1'b1;
                            n_tap       = '0;
                            n_state     = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (last_tap) begin
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, phase, configuration and tap counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_decim <= DECIM_RESET;
            r_taps  <= TAPS_RESET;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_decim <= n_decim;
            r_taps  <= n_taps;
            r_tap   <= n_tap;
        end
    end

endmodule

// ===== hdl/dfir_datapath.sv =====
// ----------------------------------------------------------------------------
// dfir_datapath
// Delay line and coefficient memories, shared multiply-accumulate pipe,
// rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module dfir_datapath #(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // input payload
    input  logic signed [SAMPLE_BITS-1:0]            i_sample_in,
    input  logic [dfir_pkg::COEF_IDX_BITS-1:0]       i_coef_index,
    input  logic signed [dfir_pkg::COEF_BITS-1:0]    i_coef_value,
    // controller link
    input  dfir_pkg::t_dp_cmd                        i_cmd,
    input  logic [$clog2(MAX_TAPS)-1:0]              i_tap,
    output dfir_pkg::t_dp_stat                       o_stat,
    // output channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]            o_filtered_out
);
    import dfir_pkg::*;

    localparam int TAP_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int IDX_W  = ((TAP_W > COEF_IDX_BITS) ? TAP_W : COEF_IDX_BITS) + 1;
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + TAP_W + 1;
    localparam int RND_W  = ACC_W - FRAC_SHIFT;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // memories
    logic signed [SAMPLE_BITS-1:0] delay_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_mem  [MAX_TAPS];

    logic [TAP_W-1:0]              r_wr_ptr;
    logic [TAP_W-1:0]              r_rd_ptr;
    logic [CNT_W-1:0]              r_fill;

    logic                          r_rd_valid;
    logic                          r_tap_ok;
    logic signed [SAMPLE_BITS-1:0] r_smp_q;
    logic signed [COEF_BITS-1:0]   r_coef_q;
    logic                          r_prod_valid;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [RND_W-1:0]       r_round;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [IDX_W-1:0]              coef_idx_ext;
    logic                          coef_idx_ok;
    logic signed [SAMPLE_BITS-1:0] smp_gated;
    logic signed [ACC_W-1:0]       n_sum;
    logic signed [SAMPLE_BITS-1:0] n_sat;

    assign coef_idx_ext = IDX_W'(i_coef_index);
    assign coef_idx_ok  = coef_idx_ext < IDX_W'(MAX_TAPS);

    // Write the delay line at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            delay_mem[r_wr_ptr] <= i_sample_in;
        end
        if (i_cmd.issue) begin
            r_smp_q <= delay_mem[r_rd_ptr];
        end
    end

    // Write the coefficient store; drop loads beyond the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && coef_idx_ok) begin
            coef_mem[coef_idx_ext[TAP_W-1:0]] <= i_coef_value;
        end
        if (i_cmd.issue) begin
            r_coef_q <= coef_mem[i_tap];
        end
    end

    // Advance write pointer and fill count; load and walk the read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else if (i_cmd.push) begin
            if (r_wr_ptr == TAP_W'(MAX_TAPS - 1)) begin
                r_wr_ptr <= '0;
            end else begin
                r_wr_ptr <= r_wr_ptr + TAP_W'(1);
            end
            if (r_fill != CNT_W'(MAX_TAPS)) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_ptr <= r_wr_ptr;
        end else if (i_cmd.issue) begin
            if (r_rd_ptr == '0) begin
                r_rd_ptr <= TAP_W'(MAX_TAPS - 1);
            end else begin
                r_rd_ptr <= r_rd_ptr - TAP_W'(1);
            end
        end
    end

    // MAC pipe: read, multiply, accumulate; unwritten delay slots read as zero
    assign smp_gated = r_tap_ok ? r_smp_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
        end else begin
            r_rd_valid   <= i_cmd.issue;
            r_prod_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tap_ok <= CNT_W'(i_tap) < r_fill;
        r_prod   <= PROD_W'(r_coef_q) * PROD_W'(smp_gated);
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up and drop the fraction
    assign n_sum = r_acc + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_round <= n_sum[ACC_W-1:FRAC_SHIFT];
        end
    end

    // Saturate to the sample range
    always_comb begin
        if (r_round > RND_W'(SAT_HI)) begin
            n_sat = SAT_HI;
        end else if (r_round < RND_W'(SAT_LO)) begin
            n_sat = SAT_LO;
        end else begin
            n_sat = r_round[SAMPLE_BITS-1:0];
        end
    end

    // Output register: load on emit, clear when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_sat;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_out   = r_out;
    assign o_stat.pipe_busy = r_rd_valid || r_prod_valid;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ===== hdl/decimating_fir_filter.sv =====
// ----------------------------------------------------------------------------
// decimating_fir_filter
// Streaming decimating FIR filter with a single shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): each beat either loads one Q1.17
// coefficient (opcode load) or pushes one Q1.15 sample (opcode push).
// Output channel (o_out_valid / i_out_stall): one filtered, saturated sample
// for every decim_factor pushed samples, starting with the first push.
// Configuration channel (i_cfg_valid / o_cfg_ready): decim_factor and
// taps_in_use; write only while the filter is idle.
// Sequence: a load or a push that gives no output leaves the filter ready for
// the next beat. A push that gives an output holds off the input while it
// takes one MAC step per tap through the single multiplier, drains the pipe,
// rounds, and loads the output register once that is free. The output
// register frees the input side: the next beat is taken while a result is
// still waiting.
// Reset clears the delay line (through a fill count), the write pointer and
// the phase, and restores decim_factor 10 and taps_in_use 151. A stalled
// receiver holds the output beat; a new result waits until it is taken.
// ----------------------------------------------------------------------------
module decimating_fir_filter #(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // input channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_opcode,
    input  logic signed [SAMPLE_BITS-1:0]            i_sample_in,
    input  logic [dfir_pkg::COEF_IDX_BITS-1:0]       i_coef_index,
    input  logic signed [dfir_pkg::COEF_BITS-1:0]    i_coef_value,
    // output channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]            o_filtered_out,
    // configuration channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [dfir_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [dfir_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import dfir_pkg::*;

    localparam int TAP_W = $clog2(MAX_TAPS);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [TAP_W-1:0] tap;

    dfir_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_tap       (tap)
    );

    dfir_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_in    (i_sample_in),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .i_cmd          (cmd),
        .i_tap          (tap),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_filtered_out (o_filtered_out)
    );

    // MAC steps only run while the input side is held off
    a_issue_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> o_in_stall)
        else $error("tap issued while input channel open");

    // A new result never overwrites one the receiver is still holding
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("result emitted over a stalled output beat");

    // The MAC pipe is empty whenever a new beat can be taken
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !stat.pipe_busy)
        else $error("MAC pipe busy while idle");

    // A coefficient load leaves the filter ready for the next beat
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_opcode == OP_LOAD)) |=> !o_in_stall)
        else $error("coefficient load did not complete in one cycle");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimating FIR filter. Coefficient loads and
// sample pushes are driven in random bursts against a randomly stalling
// receiver. A cycle-free model of the tap sum, rounding, saturation and
// decimation phase predicts each filtered sample, which is compared against
// the output channel in order. Directed beats cover the field and register
// extremes before several randomised register settings are run.
// ----------------------------------------------------------------------------
module tb;
    import dfir_pkg::*;

    localparam int MAX_TAPS       = 256;
    localparam int SAMPLE_BITS    = 16;
    localparam int ITEM_TARGET    = 1400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = MAX_TAPS + 40;
    localparam int MAX_REPORTS    = 10;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [COEF_IDX_BITS-1:0]      cidx;
        logic signed [COEF_BITS-1:0]   cval;
    } t_fir_beat;

    // ------------------------------------------------------------------------
    // Filter model and output scoreboard
    // ------------------------------------------------------------------------
    class t_scoreboard;
        logic signed [COEF_BITS-1:0]   coefs   [MAX_TAPS];
        logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
        int                            head;
        int                            phase;
        logic [DECIM_BITS-1:0]         decim;
        logic [TAPS_BITS-1:0]          taps;
        logic signed [SAMPLE_BITS-1:0] pending_outputs [$];
        int                            n_errors;
        int                            n_results;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (coefs[i]) coefs[i] = '0;
            head      = 0;
            phase     = 0;
            decim     = DECIM_RESET;
            taps      = TAPS_RESET;
            n_errors  = 0;
            n_results = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_DECIM_FACTOR: decim = data[DECIM_BITS-1:0];
                REG_TAPS_IN_USE:  taps  = data[TAPS_BITS-1:0];
                default: ;
            endcase
        endfunction

        // taps actually summed: zero counts as one, clip at the store depth
        function int taps_now();
            if (taps == 0) return 1;
            if (taps > MAX_TAPS) return MAX_TAPS;
            return int'(taps);
        endfunction

        function void apply_beat(t_fir_beat b);
            longint acc;
            longint sum;
            int     factor;
            if (b.op == OP_LOAD) begin
                coefs[b.cidx] = b.cval;
                return;
            end
            history[head] = b.sample;
            // filter only on phase zero; tap 0 is the sample just pushed
            if (phase == 0) begin
                acc = 0;
                for (int k = 0; k < taps_now(); k++) begin
                    acc += longint'(coefs[k]) *
                           longint'(history[(head - k + MAX_TAPS) % MAX_TAPS]);
                end
                // round half up, drop the coefficient fraction, clamp
                sum = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
                if (sum > SAT_HI) sum = SAT_HI;
                else if (sum < SAT_LO) sum = SAT_LO;
                pending_outputs.insert(pending_outputs.size(), sum[SAMPLE_BITS-1:0]);
            end
            head = (head + 1) % MAX_TAPS;
            // advance phase; a phase past a lowered factor wraps to zero
            factor = (decim == 0) ? 1 : ((decim > DECIM_MAX) ? DECIM_MAX : int'(decim));
            phase = (phase + 1 >= factor) ? 0 : phase + 1;
        endfunction

        function void check_output(logic signed [SAMPLE_BITS-1:0] got);
            logic signed [SAMPLE_BITS-1:0] want;
            n_results++;
            if (pending_outputs.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("ERROR: filtered_out %0d with none pending", got);
            end else begin
                want = pending_outputs.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: filtered_out expected %0d got %0d", want, got);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs
    // ------------------------------------------------------------------------
    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_in_valid   = 1'b0;
    logic                              i_opcode     = OP_PUSH;
    logic signed [SAMPLE_BITS-1:0]     i_sample_in  = '0;
    logic [COEF_IDX_BITS-1:0]          i_coef_index = '0;
    logic signed [COEF_BITS-1:0]       i_coef_value = '0;
    logic                              i_out_stall  = 1'b0;
    logic                              i_cfg_valid  = 1'b0;
    logic [CFG_IDX_BITS-1:0]           i_cfg_index  = REG_DECIM_FACTOR;
    logic [CFG_DATA_BITS-1:0]          i_cfg_data   = '0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic signed [SAMPLE_BITS-1:0]     o_filtered_out;
    logic                              o_cfg_ready;

    t_scoreboard   sb;
    bit            coef_seen [MAX_TAPS];
    int            n_items    = 0;
    int            burst_left = 0;
    int            stall_left = 0;
    int            idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    decimating_fir_filter #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_sample_in    (i_sample_in),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_filtered_out (o_filtered_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Receiver back-pressure: runs of stall and no stall of random length
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left  <= $urandom_range(1, 24);
            i_out_stall <= ($urandom_range(0, 2) == 0);
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // Check output beats and watch for a hung handshake
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_output(o_filtered_out);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic t_fir_beat push_beat(int s);
        t_fir_beat b;
        b.op     = OP_PUSH;
        b.sample = SAMPLE_BITS'(s);
        b.cidx   = COEF_IDX_BITS'($urandom);
        b.cval   = COEF_BITS'($urandom);
        return b;
    endfunction

    function automatic t_fir_beat load_beat(int idx, int v);
        t_fir_beat b;
        b.op     = OP_LOAD;
        b.sample = SAMPLE_BITS'($urandom);
        b.cidx   = COEF_IDX_BITS'(idx);
        b.cval   = COEF_BITS'(v);
        return b;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(t_fir_beat b);
        int gap;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_opcode     <= b.op;
        i_sample_in  <= b.sample;
        i_coef_index <= b.cidx;
        i_coef_value <= b.cval;
        do @(posedge i_clk); while (o_in_stall);
        sb.apply_beat(b);
        if (b.op == OP_LOAD) coef_seen[b.cidx] = 1'b1;
        n_items++;
        // sender bursts: hold valid within a burst, drop it for the gap after
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 20);
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every filtered sample is back and the block is quiet
    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly pushes; load any coefficient the current taps would read unwritten
    task automatic run_random(int n);
        t_fir_beat b;
        int        done;
        int        hole;
        done = 0;
        while (done < n) begin
            b = push_beat(int'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                b.op = OP_LOAD;
                if ($urandom_range(0, 1) == 0) b.cval = b.cval >>> $urandom_range(1, 12);
                done++;
            end else begin
                hole = -1;
                for (int k = sb.taps_now() - 1; k >= 0; k--)
                    if (!coef_seen[k]) hole = k;
                if (hole >= 0) begin
                    b.op   = OP_LOAD;
                    b.cidx = COEF_IDX_BITS'(hole);
                    b.cval = b.cval >>> $urandom_range(2, 10);
                end else begin
                    done++;
                end
            end
            send_beat(b);
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_BITS-1:0] decim_val,
                             logic [CFG_DATA_BITS-1:0] taps_val, int n);
        cfg_write(REG_DECIM_FACTOR, decim_val);
        cfg_write(REG_TAPS_IN_USE, taps_val);
        run_random(n);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_BITS-1:0] d;
        logic [CFG_DATA_BITS-1:0] t;
        sb = new();
        foreach (coef_seen[i]) coef_seen[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // four taps, every push filtered; coefficient and sample extremes
        cfg_write(REG_TAPS_IN_USE, 4);
        cfg_write(REG_DECIM_FACTOR, 1);
        send_beat(load_beat(0, 131071));
        send_beat(load_beat(1, -131072));
        send_beat(load_beat(2, 1));
        send_beat(load_beat(3, -1));
        send_beat(push_beat(32767));
        send_beat(push_beat(-32768));
        send_beat(push_beat(-32768));
        send_beat(push_beat(0));
        send_beat(push_beat(1));
        send_beat(push_beat(-1));
        // minus one times the most negative sample clips high
        send_beat(load_beat(0, -131072));
        send_beat(push_beat(-32768));
        send_beat(load_beat(255, 12345));
        send_beat(push_beat(16384));
        settle();

        // oversized factor saturates, zero taps counts as one
        cfg_write(REG_DECIM_FACTOR, 11'h7FF);
        cfg_write(REG_TAPS_IN_USE, 0);
        repeat (5) send_beat(push_beat(int'($urandom)));
        settle();

        // factor lowered below the running phase: wrap without an output
        cfg_write(REG_DECIM_FACTOR, 3);
        cfg_write(REG_TAPS_IN_USE, 2);
        repeat (3) send_beat(push_beat(int'($urandom)));
        settle();

        // fixed settings at the register extremes, then random settings
        run_phase(0, 16, 150);
        run_phase(1024, 5, 120);
        run_phase(2, 256, 60);
        run_phase(11'h7FF, 11'h7FF, 40);
        run_phase(1, 1, 80);
        while (n_items < ITEM_TARGET) begin
            d = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom_range(0, 2047))
                                            : CFG_DATA_BITS'($urandom_range(1, 12));
            t = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom_range(0, 511))
                                            : CFG_DATA_BITS'($urandom_range(1, 32));
            run_phase(d, t, 100);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending_outputs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
